>>> rtl/brad_pkg.sv
// Shared types, constants and register codes of the breathing rate anomaly detector.
`default_nettype none
package brad_pkg;

    localparam int VOTE_MAX    = 8;
    localparam int HEAD_W      = (VOTE_MAX > 1) ? $clog2(VOTE_MAX) : 1;
    localparam int CNT_W       = $clog2(VOTE_MAX + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int RATE_W   = 12;
    localparam int TIME_W   = 16;
    localparam int WIN_W    = 4;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 3;

    localparam logic [REGIDX_W-1:0] REG_TACHY_THRESHOLD = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BRADY_THRESHOLD = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_APNEA_TRIGGER   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_STRIDE_TIME     = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_HIST_LEN        = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_QUORUM          = 3'd5;

    localparam logic [RATE_W-1:0] TACHY_RESET  = 12'd400;
    localparam logic [RATE_W-1:0] BRADY_RESET  = 12'd128;
    localparam logic [TIME_W-1:0] APNEA_RESET  = 16'd320;
    localparam logic [TIME_W-1:0] STRIDE_RESET = 16'd80;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 4'd3;
    localparam logic [WIN_W-1:0]  NEEDED_RESET = 4'd3;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_APNEA = 2'd1,
        KIND_FAST  = 2'd2,
        KIND_SLOW  = 2'd3
    } alert_kind_t;

    typedef struct packed {
        logic [RATE_W-1:0] tachy_threshold;
        logic [RATE_W-1:0] brady_threshold;
        logic [TIME_W-1:0] apnea_trigger;
        logic [TIME_W-1:0] stride_time;
        logic [WIN_W-1:0]  hist_len;
        logic [WIN_W-1:0]  quorum;
    } cfg_t;

    typedef struct packed {
        logic              rate_valid;
        logic              fast_vote;
        logic              slow_vote;
        logic [RATE_W-1:0] rate;
    } vote_req_t;

endpackage
`default_nettype wire

>>> rtl/brad_front.sv
// Front stage: classifies each incoming window into fast and slow votes.
`default_nettype none
module brad_front (
    input  wire brad_pkg::cfg_t             cfg,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             rate_valid,
    input  wire [brad_pkg::RATE_W-1:0]      rate,
    output logic                            push,
    output brad_pkg::vote_req_t             push_req,
    input  wire                             queue_full
);
    import brad_pkg::*;

    always_comb
    begin
        in_ready             = !queue_full;
        push                 = in_valid && !queue_full;
        push_req.rate_valid  = rate_valid;
        push_req.rate        = rate;
        push_req.fast_vote   = rate_valid && (rate > cfg.tachy_threshold);
        push_req.slow_vote   = rate_valid && (rate < cfg.brady_threshold);
    end

endmodule
`default_nettype wire

>>> rtl/brad_queue.sv
// Short queue of classified requests between the front and back stages.
`default_nettype none
module brad_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wire brad_pkg::vote_req_t push_req,
    output logic                  full,
    input  wire                   pop,
    output logic                  pop_valid,
    output brad_pkg::vote_req_t   pop_req
);
    import brad_pkg::*;

    vote_req_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        pop_valid = (count_reg != '0);
        pop_req   = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/brad_back.sv
// Back stage: apnea timer, vote histories, alert decision and the output register.
`default_nettype none
module brad_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire brad_pkg::cfg_t         cfg,
    input  wire                         req_valid,
    input  wire brad_pkg::vote_req_t    req,
    output logic                        req_pop,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [1:0]                  alert_kind,
    output logic [brad_pkg::WIN_W-1:0]  window_used,
    output logic [brad_pkg::WIN_W-1:0]  vote_count,
    output logic [brad_pkg::RATE_W-1:0] alert_rate,
    output logic [brad_pkg::TIME_W-1:0] apnea_time
);
    import brad_pkg::*;

    logic                  occupied_reg;
    logic                  occupied_next;
    logic [TIME_W-1:0]     timer_reg;
    logic [TIME_W-1:0]     timer_next;
    logic [VOTE_MAX-1:0]   fast_reg;
    logic [VOTE_MAX-1:0]   fast_next;
    logic [VOTE_MAX-1:0]   slow_reg;
    logic [VOTE_MAX-1:0]   slow_next;
    logic [HEAD_W-1:0]     head_reg;
    logic [HEAD_W-1:0]     head_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    alert_kind_t           last_reg;
    alert_kind_t           last_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            kind_reg;
    logic [1:0]            kind_next;
    logic [WIN_W-1:0]      window_reg;
    logic [WIN_W-1:0]      window_next;
    logic [WIN_W-1:0]      count_reg;
    logic [WIN_W-1:0]      count_next;
    logic [RATE_W-1:0]     arate_reg;
    logic [RATE_W-1:0]     arate_next;
    logic [TIME_W-1:0]     atime_reg;
    logic [TIME_W-1:0]     atime_next;

    logic [CNT_W-1:0]      win_eff;
    logic [CNT_W-1:0]      need_eff;
    logic [TIME_W:0]       timer_sum;
    logic [HEAD_W-1:0]     head_eff;
    logic [CNT_W-1:0]      fill_eff;
    logic [CNT_W-1:0]      head_inc;
    logic [CNT_W-1:0]      nfast;
    logic [CNT_W-1:0]      nslow;
    alert_kind_t           cur;

    always_comb
    begin
        req_pop = req_valid && (!out_valid_reg || out_ready);

        if (cfg.hist_len == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (32'(cfg.hist_len) > 32'(VOTE_MAX))
        begin
            win_eff = CNT_W'(VOTE_MAX);
        end
        else
        begin
            win_eff = CNT_W'(cfg.hist_len);
        end

        if (cfg.quorum == '0)
        begin
            need_eff = CNT_W'(1);
        end
        else if (32'(cfg.quorum) > 32'(win_eff))
        begin
            need_eff = win_eff;
        end
        else
        begin
            need_eff = CNT_W'(cfg.quorum);
        end

        occupied_next = occupied_reg;
        timer_next    = timer_reg;
        timer_sum     = {1'b0, timer_reg} + {1'b0, cfg.stride_time};
        if (req.rate_valid)
        begin
            occupied_next = 1'b1;
            timer_next    = '0;
        end
        else if (occupied_reg)
        begin
            timer_next = timer_sum[TIME_W] ? '1 : timer_sum[TIME_W-1:0];
        end

        head_eff = (CNT_W'(head_reg) >= win_eff) ? '0 : head_reg;
        fill_eff = (fill_reg > win_eff) ? win_eff : fill_reg;

        fast_next           = fast_reg;
        slow_next           = slow_reg;
        fast_next[head_eff] = req.fast_vote;
        slow_next[head_eff] = req.slow_vote;

        head_inc  = CNT_W'(head_eff) + 1'b1;
        head_next = (head_inc == win_eff) ? '0 : HEAD_W'(head_inc);
        fill_next = (fill_eff < win_eff) ? fill_eff + 1'b1 : fill_eff;

        nfast = '0;
        nslow = '0;
        for (int i = 0; i < VOTE_MAX; i++)
        begin
            if (CNT_W'(i) < fill_next)
            begin
                nfast = nfast + CNT_W'(fast_next[i]);
                nslow = nslow + CNT_W'(slow_next[i]);
            end
        end

        if (occupied_next && (timer_next >= cfg.apnea_trigger))
        begin
            cur = KIND_APNEA;
        end
        else if (nfast >= need_eff)
        begin
            cur = KIND_FAST;
        end
        else if (nslow >= need_eff)
        begin
            cur = KIND_SLOW;
        end
        else
        begin
            cur = KIND_NONE;
        end
        last_next = cur;

        kind_next   = '0;
        window_next = '0;
        count_next  = '0;
        arate_next  = '0;
        atime_next  = '0;
        if ((cur != KIND_NONE) && (cur != last_reg))
        begin
            kind_next   = cur;
            window_next = WIN_W'(win_eff);
            case (cur)
                KIND_APNEA:
                begin
                    count_next = WIN_W'(win_eff);
                    atime_next = timer_next;
                end
                KIND_FAST:
                begin
                    count_next = WIN_W'(nfast);
                    arate_next = req.rate;
                end
                default:
                begin
                    count_next = WIN_W'(nslow);
                    arate_next = req.rate;
                end
            endcase
        end

        if (req_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg  <= 1'b0;
            timer_reg     <= '0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            last_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (req_pop)
            begin
                occupied_reg <= occupied_next;
                timer_reg    <= timer_next;
                fast_reg     <= fast_next;
                slow_reg     <= slow_next;
                head_reg     <= head_next;
                fill_reg     <= fill_next;
                last_reg     <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            kind_reg   <= kind_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            arate_reg  <= arate_next;
            atime_reg  <= atime_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign alert_kind  = kind_reg;
    assign window_used = window_reg;
    assign vote_count  = count_reg;
    assign alert_rate  = arate_reg;
    assign apnea_time  = atime_reg;

endmodule
`default_nettype wire

>>> rtl/breathing_rate_anomaly_detector_core.sv
// Top level of the breathing rate anomaly detector: register file, front, queue and back.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     rate_valid, rate
//   output    out_valid / out_ready   alert_kind, window_used, vote_count, alert_rate,
//                                     apnea_time
//   config    APB (psel, penable)     paddr, pwdata, prdata
//
// One request is taken every cycle while in_ready is high; it is written into the queue, and its
// result is loaded into the output register at the edge that pops it, to be taken at the next edge.
// The back stage updates the timer and vote histories as it pops a request, so the rate is set by
// the output register: a result that is not taken stalls the back stage, and the two-entry
// queue then fills and drops in_ready. Reset clears control state and loads the register defaults.
`default_nettype none
module breathing_rate_anomaly_detector_core (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire                            rate_valid,
    input  wire [brad_pkg::RATE_W-1:0]     rate,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [1:0]                     alert_kind,
    output logic [brad_pkg::WIN_W-1:0]     window_used,
    output logic [brad_pkg::WIN_W-1:0]     vote_count,
    output logic [brad_pkg::RATE_W-1:0]    alert_rate,
    output logic [brad_pkg::TIME_W-1:0]    apnea_time,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [brad_pkg::PADDR_W-1:0]    paddr,
    input  wire [brad_pkg::PDATA_W-1:0]    pwdata,
    output logic [brad_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import brad_pkg::*;

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [REGIDX_W-1:0] reg_idx;
    logic                wr_en;
    logic                push;
    vote_req_t           push_req;
    logic                queue_full;
    logic                pop;
    logic                pop_valid;
    vote_req_t           pop_req;

    always_comb
    begin
        pready   = 1'b1;
        reg_idx  = paddr[PADDR_W-1:2];
        wr_en    = psel && penable && pwrite;
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TACHY_THRESHOLD: cfg_next.tachy_threshold = pwdata[RATE_W-1:0];
                REG_BRADY_THRESHOLD: cfg_next.brady_threshold = pwdata[RATE_W-1:0];
                REG_APNEA_TRIGGER:   cfg_next.apnea_trigger   = pwdata[TIME_W-1:0];
                REG_STRIDE_TIME:     cfg_next.stride_time     = pwdata[TIME_W-1:0];
                REG_HIST_LEN:        cfg_next.hist_len        = pwdata[WIN_W-1:0];
                REG_QUORUM:          cfg_next.quorum          = pwdata[WIN_W-1:0];
                default:             cfg_next                 = cfg_reg;
            endcase
        end

        case (reg_idx)
            REG_TACHY_THRESHOLD: prdata = PDATA_W'(cfg_reg.tachy_threshold);
            REG_BRADY_THRESHOLD: prdata = PDATA_W'(cfg_reg.brady_threshold);
            REG_APNEA_TRIGGER:   prdata = PDATA_W'(cfg_reg.apnea_trigger);
            REG_STRIDE_TIME:     prdata = PDATA_W'(cfg_reg.stride_time);
            REG_HIST_LEN:        prdata = PDATA_W'(cfg_reg.hist_len);
            REG_QUORUM:          prdata = PDATA_W'(cfg_reg.quorum);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tachy_threshold <= TACHY_RESET;
            cfg_reg.brady_threshold <= BRADY_RESET;
            cfg_reg.apnea_trigger   <= APNEA_RESET;
            cfg_reg.stride_time     <= STRIDE_RESET;
            cfg_reg.hist_len        <= WINDOW_RESET;
            cfg_reg.quorum          <= NEEDED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brad_front u_front (
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rate_valid (rate_valid),
        .rate       (rate),
        .push       (push),
        .push_req   (push_req),
        .queue_full (queue_full)
    );

    brad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_req   (pop_req)
    );

    brad_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req_valid   (pop_valid),
        .req         (pop_req),
        .req_pop     (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .alert_kind  (alert_kind),
        .window_used (window_used),
        .vote_count  (vote_count),
        .alert_rate  (alert_rate),
        .apnea_time  (apnea_time)
    );

endmodule
`default_nettype wire
